// ----- design/pareto_front_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// pareto_front_filter_unit_macros.svh
// Assertion macros used by the top-level front filter design file.
// ----------------------------------------------------------------------------
`ifndef PARETO_FRONT_FILTER_UNIT_MACROS_SVH
`define PARETO_FRONT_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PFF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pareto front filter: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PFF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pareto front filter: next-cycle check failed");

`endif

// ----- design/pff_pkg.sv -----
// ----------------------------------------------------------------------------
// pff_pkg
// Types and constants of the Pareto front filter.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam int PFF_MAX_RECORDS = 32;
    localparam int PFF_LABEL_W     = 6;
    localparam int PFF_VALUE_W     = 32;

    // One input request
    typedef struct packed {
        logic [PFF_LABEL_W-1:0] record_label;
        logic [PFF_VALUE_W-1:0] makespan;
        logic [PFF_VALUE_W-1:0] work;
        logic                   is_last;
    } pff_in_t;

    // One result
    typedef struct packed {
        logic [PFF_LABEL_W-1:0] front_label;
        logic [PFF_VALUE_W-1:0] front_makespan;
        logic [PFF_VALUE_W-1:0] front_work;
        logic                   end_of_front;
        logic                   records_dropped;
    } pff_out_t;

    // Record held in a cell
    typedef struct packed {
        logic [PFF_LABEL_W-1:0] label;
        logic [PFF_VALUE_W-1:0] makespan;
        logic [PFF_VALUE_W-1:0] work;
    } pff_rec_t;

    // Chain control, common to all cells
    typedef struct packed {
        logic insert;
        logic drain;
    } pff_cell_ctrl_t;

    // Control from the sequencer to the front stage
    typedef struct packed {
        logic step;
        logic flush;
        logic dropped;
    } pff_front_ctrl_t;

endpackage

// ----- design/pff_cell.sv -----
// ----------------------------------------------------------------------------
// pff_cell
// One insertion cell: holds one record, takes the new record or its left
// neighbor's record on insert, takes its right neighbor's record on drain.
// ----------------------------------------------------------------------------
module pff_cell
    import pff_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  pff_cell_ctrl_t ctrl,
    input  pff_rec_t       new_rec,
    input  logic           prev_take,
    input  pff_rec_t       prev_rec,
    input  logic           prev_valid,
    input  pff_rec_t       next_rec,
    input  logic           next_valid,
    output logic           take,
    output pff_rec_t       rec,
    output logic           valid
);

    pff_rec_t rec_reg, rec_next;
    logic     valid_reg, valid_next;

    // The new record belongs at or before this cell when the cell is empty
    // or holds a strictly larger makespan (ties keep load order)
    assign take = !valid_reg || (rec_reg.makespan > new_rec.makespan);

    // Select shift-in, insert or hold
    always_comb begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.drain) begin
            rec_next   = next_rec;
            valid_next = next_valid;
        end else if (ctrl.insert && take) begin
            if (prev_take) begin
                rec_next   = prev_rec;
                valid_next = prev_valid;
            end else begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

// ----- design/pff_front.sv -----
// ----------------------------------------------------------------------------
// pff_front
// Front stage: filters the drained records by work, holds the latest front
// record until its successor or the end of the set is known, and drives the
// result register.
// ----------------------------------------------------------------------------
module pff_front
    import pff_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  pff_front_ctrl_t ctrl,
    input  pff_rec_t        head,
    output logic            slot_free,
    output logic            m_valid,
    input  logic            m_ready,
    output pff_out_t        m_data
);

    logic                   first_reg, first_next;
    logic                   pend_valid_reg, pend_valid_next;
    pff_rec_t               pend_reg, pend_next;
    logic [PFF_VALUE_W-1:0] ref_work_reg, ref_work_next;
    logic                   out_valid_reg, out_valid_next;
    pff_out_t               out_reg, out_next;
    logic                   keep;

    assign slot_free = !out_valid_reg || m_ready;
    assign keep      = first_reg || (head.work <= ref_work_reg);

    // Advance the pending record to the output, replace or flush it
    always_comb begin
        first_next      = first_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ref_work_next   = ref_work_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        if (ctrl.step && keep) begin
            if (pend_valid_reg) begin
                out_next.front_label     = pend_reg.label;
                out_next.front_makespan  = pend_reg.makespan;
                out_next.front_work      = pend_reg.work;
                out_next.end_of_front    = 1'b0;
                out_next.records_dropped = ctrl.dropped;
                out_valid_next           = 1'b1;
            end
            pend_next       = head;
            pend_valid_next = 1'b1;
            ref_work_next   = head.work;
            first_next      = 1'b0;
        end else if (ctrl.flush) begin
            if (pend_valid_reg) begin
                out_next.front_label     = pend_reg.label;
                out_next.front_makespan  = pend_reg.makespan;
                out_next.front_work      = pend_reg.work;
                out_next.end_of_front    = 1'b1;
                out_next.records_dropped = ctrl.dropped;
                out_valid_next           = 1'b1;
            end
            pend_valid_next = 1'b0;
            first_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            first_reg      <= first_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        ref_work_reg <= ref_work_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- design/pareto_front_filter_unit.sv -----
// ----------------------------------------------------------------------------
// pareto_front_filter_unit
// Two-objective Pareto front of schedule records, built on a chain of
// insertion cells.
// ----------------------------------------------------------------------------
// Records load at one request per cycle into a chain of MAX_RECORDS cells
// that stays sorted by makespan (equal makespans keep load order); records
// that find the chain full are dropped and flagged on every result of the
// set. The request marked last closes the set: s_ready then falls while the
// chain drains one cell per cycle into the front stage whenever the result
// register is free; the drain is paced by the single result register. After
// the final result has been handed to the result register the chain is
// empty and loading resumes.
module pareto_front_filter_unit
    import pff_pkg::*;
#(
    parameter int MAX_RECORDS = PFF_MAX_RECORDS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pff_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pff_out_t m_data
);

`include "pareto_front_filter_unit_macros.svh"

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                   state_reg, state_next;
    logic                   overflow_reg, overflow_next;
    logic                   accept, full, slot_free;
    pff_cell_ctrl_t         cell_ctrl;
    pff_front_ctrl_t        front_ctrl;
    pff_rec_t               new_rec;
    pff_rec_t               cell_rec   [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] cell_take;
    logic [MAX_RECORDS-1:0] cell_valid;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;
    assign full    = cell_valid[MAX_RECORDS-1];

    assign new_rec.label    = s_data.record_label;
    assign new_rec.makespan = s_data.makespan;
    assign new_rec.work     = s_data.work;

    // Insert while loading, shift toward the head while draining
    assign cell_ctrl.insert   = accept && !full;
    assign cell_ctrl.drain    = front_ctrl.step;
    assign front_ctrl.step    = (state_reg == ST_DRAIN) && slot_free && cell_valid[0];
    assign front_ctrl.flush   = (state_reg == ST_DRAIN) && slot_free && !cell_valid[0];
    assign front_ctrl.dropped = overflow_reg;

    // Sequence loading and draining, track dropped records
    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && full) begin
                    overflow_next = 1'b1;
                end
                if (accept && s_data.is_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (front_ctrl.flush) begin
                    overflow_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // Chain of insertion cells
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        logic     prev_take, prev_valid, next_valid;
        pff_rec_t prev_rec, next_rec;

        if (i == 0) begin : g_head
            assign prev_take  = 1'b0;
            assign prev_valid = 1'b0;
            assign prev_rec   = new_rec;
        end else begin : g_body
            assign prev_take  = cell_take[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_rec   = cell_rec[i-1];
        end

        if (i == MAX_RECORDS - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_rec   = new_rec;
        end else begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_rec   = cell_rec[i+1];
        end

        pff_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .new_rec    (new_rec),
            .prev_take  (prev_take),
            .prev_rec   (prev_rec),
            .prev_valid (prev_valid),
            .next_rec   (next_rec),
            .next_valid (next_valid),
            .take       (cell_take[i]),
            .rec        (cell_rec[i]),
            .valid      (cell_valid[i])
        );
    end

    pff_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (front_ctrl),
        .head      (cell_rec[0]),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Occupied cells stay packed at the head of the chain
    `PFF_ASSERT_IMPL(a_chain_packed, aclk, aresetn, !cell_valid[0], cell_valid == '0)
    // The last request always starts the drain
    `PFF_ASSERT_NEXT(a_last_drains, aclk, aresetn, accept && s_data.is_last,
                     state_reg == ST_DRAIN)
    // Closing the set leaves a final result flagged as end of front
    `PFF_ASSERT_NEXT(a_flush_ends, aclk, aresetn, front_ctrl.flush,
                     m_valid && m_data.end_of_front)
    // A request that meets a full chain is flagged
    `PFF_ASSERT_NEXT(a_drop_flag, aclk, aresetn, accept && full, overflow_reg)

endmodule

// ----- tb/sv/tb_pareto_front_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_pareto_front_filter_unit
// Drives record sets into the Pareto front filter and checks every emitted
// front record against a behavioral predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
// Directed sets cover the field extremes, makespan ties, equal work values
// and reverse-order loading. Random sets follow, mostly small, with a few that
// fill or overrun the store. The sender works in bursts with gaps, and the
// receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import pff_pkg::*;

// Scoreboard: sorted record store and the queue of front records still due
class front_scoreboard;
    pff_rec_t    rec_store [PFF_MAX_RECORDS];
    int unsigned rec_count;
    bit          overflow_flag;
    pff_out_t    due_front [$];
    int unsigned mismatch_count;

    function new();
        rec_count      = 0;
        overflow_flag  = 1'b0;
        mismatch_count = 0;
    endfunction

    // Insert an accepted request; on the last one, predict the front
    function void note_request(pff_in_t req);
        int unsigned pos;
        int unsigned picks [$];
        logic [PFF_VALUE_W-1:0] best_work;
        pff_out_t res;
        if (rec_count < PFF_MAX_RECORDS) begin
            pos = rec_count;
            // shift later makespans up, keeping load order on ties
            while (pos > 0 && rec_store[pos-1].makespan > req.makespan) begin
                rec_store[pos] = rec_store[pos-1];
                pos--;
            end
            rec_store[pos].label    = req.record_label;
            rec_store[pos].makespan = req.makespan;
            rec_store[pos].work     = req.work;
            rec_count++;
        end else begin
            overflow_flag = 1'b1;
        end
        if (!req.is_last)
            return;
        if (rec_count > 0) begin
            picks.push_back(0);
            best_work = rec_store[0].work;
            for (int unsigned i = 1; i < rec_count; i++) begin
                if (rec_store[i].work <= best_work) begin
                    picks.push_back(i);
                    best_work = rec_store[i].work;
                end
            end
            foreach (picks[k]) begin
                res.front_label     = rec_store[picks[k]].label;
                res.front_makespan  = rec_store[picks[k]].makespan;
                res.front_work      = rec_store[picks[k]].work;
                res.end_of_front    = (k == picks.size() - 1);
                res.records_dropped = overflow_flag;
                due_front.push_back(res);
            end
        end
        rec_count     = 0;
        overflow_flag = 1'b0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare one accepted result with the oldest due front record
    task check_result(pff_out_t got);
        pff_out_t want;
        if (due_front.size() == 0) begin
            report_mismatch("result with nothing due, label", 32'(got.front_label), 32'h0);
            return;
        end
        want = due_front.pop_front();
        if (got.front_label !== want.front_label)
            report_mismatch("front_label", 32'(got.front_label), 32'(want.front_label));
        if (got.front_makespan !== want.front_makespan)
            report_mismatch("front_makespan", got.front_makespan, want.front_makespan);
        if (got.front_work !== want.front_work)
            report_mismatch("front_work", got.front_work, want.front_work);
        if (got.end_of_front !== want.end_of_front)
            report_mismatch("end_of_front", 32'(got.end_of_front), 32'(want.end_of_front));
        if (got.records_dropped !== want.records_dropped)
            report_mismatch("records_dropped", 32'(got.records_dropped),
                            32'(want.records_dropped));
    endtask
endclass

module tb_pareto_front_filter_unit;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 250;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned IN_BITS      = $bits(pff_in_t);

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EXTREME
    } value_mode_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pff_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pff_out_t m_data;

    front_scoreboard sb;
    int unsigned     items_sent   = 0;
    int unsigned     burst_left   = 0;
    int unsigned     cycle_count  = 0;
    logic [31:0]     rx_cycle     = '0;

    pareto_front_filter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_pareto_front_filter_unit: errors");
            $finish;
        end
    end

    // Check accepted results, then pick the next ready value
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_result(m_data);
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= rx_cycle[3];
            end
        endcase
    end

    function automatic logic [PFF_VALUE_W-1:0] pick_value(value_mode_t mode);
        logic [PFF_VALUE_W-1:0] v;
        case (mode)
            VAL_NARROW: v = PFF_VALUE_W'($urandom_range(0, 15));
            VAL_EXTREME: begin
                case ($urandom_range(0, 2))
                    0: v = '0;
                    1: v = '1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Present one request, hold it until accepted, then maybe open a gap
    task automatic push_request(input pff_in_t req);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                // drop valid and put noise on the idle payload
                s_valid <= 1'b0;
                s_data  <= IN_BITS'({$urandom, $urandom, $urandom});
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic push_record(input logic [PFF_LABEL_W-1:0] lab,
                               input logic [PFF_VALUE_W-1:0] mk,
                               input logic [PFF_VALUE_W-1:0] wk,
                               input logic last);
        pff_in_t req;
        req.record_label = lab;
        req.makespan     = mk;
        req.work         = wk;
        req.is_last      = last;
        push_request(req);
    endtask

    // Send one random set of the given size, last marked on its final record
    task automatic push_random_set(input int unsigned set_size);
        value_mode_t mk_mode;
        value_mode_t wk_mode;
        mk_mode = value_mode_t'($urandom_range(0, 2));
        wk_mode = value_mode_t'($urandom_range(0, 2));
        for (int unsigned i = 0; i < set_size; i++)
            push_record(PFF_LABEL_W'($urandom_range(0, 63)), pick_value(mk_mode),
                        pick_value(wk_mode), (i == set_size - 1));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single records at the field extremes
        push_record(6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_record(6'h00, 32'h0000_0000, 32'h0000_0000, 1'b1);
        // equal makespans keep load order; equal work still emits
        push_record(6'd1, 32'd5, 32'd9, 1'b0);
        push_record(6'd2, 32'd5, 32'd9, 1'b0);
        push_record(6'd3, 32'd5, 32'd3, 1'b1);
        // reverse load order, every record on the front
        push_record(6'd10, 32'd40, 32'd1, 1'b0);
        push_record(6'd11, 32'd30, 32'd2, 1'b0);
        push_record(6'd12, 32'd20, 32'd3, 1'b0);
        push_record(6'd13, 32'd10, 32'd4, 1'b1);
        // dominated records mixed with extremes
        push_record(6'd20, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        push_record(6'd21, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        push_record(6'd22, 32'd100, 32'd50, 1'b0);
        push_record(6'd23, 32'd100, 32'd60, 1'b0);
        push_record(6'd24, 32'd200, 32'd50, 1'b1);
        // alternating bit patterns
        push_record(6'h2A, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        push_record(6'h15, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

        // exactly full, then overrun with the last record dropped
        push_random_set(PFF_MAX_RECORDS);
        push_random_set(PFF_MAX_RECORDS + 2);
        while (items_sent < RANDOM_ITEMS + 16) begin
            if ($urandom_range(0, 9) == 0)
                push_random_set($urandom_range(PFF_MAX_RECORDS - 2, PFF_MAX_RECORDS + 4));
            else
                push_random_set($urandom_range(1, 8));
        end
        s_valid <= 1'b0;

        // drain all due results, then watch for strays
        while (sb.due_front.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.due_front.size() == 0) begin
            $display("tb_pareto_front_filter_unit: clean");
        end else begin
            $display("tb_pareto_front_filter_unit: errors");
        end
        $finish;
    end

endmodule
